// ===== sv/bli_pkg.sv =====
`default_nettype none
package bli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int ENT_W      = 2 * VALUE_BITS;
  localparam int NUM_W      = 7;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HUM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPC   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_IN   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_HIGH = 2'd2;

  localparam logic [NUM_W-1:0] NUM_RESET = 7'd2;

endpackage
`default_nettype wire

// ===== sv/bli_ram.sv =====
`default_nettype none
module bli_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/bli_div.sv =====
`default_nettype none
module bli_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [bli_pkg::ENT_W-1:0]         dividend,
  input  logic [bli_pkg::VALUE_BITS-1:0]    divisor,
  output logic                              done,
  output logic [bli_pkg::VALUE_BITS-1:0]    quotient
);
  import bli_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  // caller guarantees the upper half of the dividend is below the divisor,
  // so the quotient fits in VALUE_BITS and one pass per quotient bit suffices
  assign trial = {rem, quo[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[ENT_W-1:VALUE_BITS];
      quo <= dividend[VALUE_BITS-1:0];
    end else if (busy) begin
      rem <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      quo <= {quo[VALUE_BITS-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== sv/bidirectional_linear_interp_table_unit.sv =====
// channel | handshake           | payload
// --------+---------------------+--------------------------------------------------
// in      | in_valid / in_stall | kind, entry_index, entry_humidity, entry_spacing,
//         |                     | query_value
// out     | out_valid/out_stall | mapped_value, range_status
// cfg     | cfg_valid/cfg_ready | cfg_data (num_points)
//
// A write beat does not stall the input. A query walks the table through
// the single read port, one entry per cycle: entry 0, the last entry, then
// a scan from entry 1 up to the segment. A clamped query ends after entry 0
// or the last entry; an interpolated one scans, multiplies and then runs the
// radix-2 divider. rst is synchronous; the table holds no reset value.
// in_stall is high while a query is in flight; a result waiting on
// out_stall does not block the input.
`default_nettype none
module bidirectional_linear_interp_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bli_pkg::KIND_W-1:0]      kind,
  input  logic [bli_pkg::IDX_W-1:0]       entry_index,
  input  logic [bli_pkg::VALUE_BITS-1:0]  entry_humidity,
  input  logic [bli_pkg::VALUE_BITS-1:0]  entry_spacing,
  input  logic [bli_pkg::VALUE_BITS-1:0]  query_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bli_pkg::NUM_W-1:0]       cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bli_pkg::VALUE_BITS-1:0]  mapped_value,
  output logic [bli_pkg::STAT_W-1:0]      range_status
);
  import bli_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD0    = 4'd1;
  localparam logic [3:0] S_RDL    = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam int VB = VALUE_BITS;

  logic [3:0]        state;
  logic [NUM_W-1:0]  num_points;
  logic [NUM_W-1:0]  n_eff;
  logic [IDX_W-1:0]  last;

  logic              in_acc;
  logic              we;
  logic [IDX_W-1:0]  raddr;
  logic [ENT_W-1:0]  rdata;
  logic [VB-1:0]     rd_x;
  logic [VB-1:0]     rd_y;

  logic              swap;
  logic [VB-1:0]     qx;
  logic [VB-1:0]     x1;
  logic [VB-1:0]     y1;
  logic [VB-1:0]     dx;
  logic [VB-1:0]     span;
  logic [VB-1:0]     dyabs;
  logic              dy_neg;
  logic [ENT_W-1:0]  prod;
  logic [IDX_W-1:0]  j;
  logic [VB-1:0]     res;
  logic [STAT_W-1:0] res_stat;
  logic              scan_more;

  logic              div_start;
  logic              div_done;
  logic [VB-1:0]     div_q;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign we        = in_acc && (kind == KIND_WRITE);
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_DSTART);

  always_comb begin
    if (num_points < NUM_W'(2)) begin
      n_eff = NUM_W'(2);
    end else if (num_points > NUM_W'(MAX_POINTS)) begin
      n_eff = NUM_W'(MAX_POINTS);
    end else begin
      n_eff = num_points;
    end
  end

  logic [NUM_W-1:0] n_last;
  assign n_last = n_eff - 1'b1;
  assign last   = n_last[IDX_W-1:0];

  // entry layout {humidity, spacing}; swap selects spacing as the search column
  assign rd_x = swap ? rdata[VB-1:0] : rdata[ENT_W-1:VB];
  assign rd_y = swap ? rdata[ENT_W-1:VB] : rdata[VB-1:0];

  assign scan_more = (j < last) && (rd_x < qx);

  always_comb begin
    case (state)
      S_RD0:   raddr = last;
      S_RDL:   raddr = IDX_W'(1);
      S_SCAN:  raddr = j + 1'b1;
      default: raddr = '0;
    endcase
  end

  bli_ram #(
    .DEPTH(MAX_POINTS),
    .WIDTH(ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (entry_index),
    .wdata ({entry_humidity, entry_spacing}),
    .raddr (raddr),
    .rdata (rdata)
  );

  bli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_points <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (kind == KIND_HUM || kind == KIND_SPC)) begin
            state <= S_RD0;
          end
        end
        S_RD0: begin
          state <= (qx <= rd_x) ? S_OUT : S_RDL;
        end
        S_RDL: begin
          state <= (qx >= rd_x) ? S_OUT : S_SCAN;
        end
        S_SCAN: begin
          if (!scan_more) begin
            state <= (rd_x <= x1 || qx < x1) ? S_OUT : S_MUL;
          end
        end
        S_MUL:    state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          qx   <= query_value;
          swap <= (kind == KIND_SPC);
        end
      end
      S_RD0: begin
        x1       <= rd_x;
        y1       <= rd_y;
        res      <= rd_y;
        res_stat <= STAT_LOW;
      end
      S_RDL: begin
        j        <= IDX_W'(1);
        res      <= rd_y;
        res_stat <= STAT_HIGH;
      end
      S_SCAN: begin
        if (scan_more) begin
          x1 <= rd_x;
          y1 <= rd_y;
          j  <= j + 1'b1;
        end else begin
          // flat or inverted segment answers with its left breakpoint
          res      <= y1;
          res_stat <= STAT_IN;
          dx       <= qx - x1;
          span     <= rd_x - x1;
          dy_neg   <= rd_y < y1;
          dyabs    <= (rd_y < y1) ? (y1 - rd_y) : (rd_y - y1);
        end
      end
      S_MUL: begin
        prod <= {{VB{1'b0}}, dyabs} * {{VB{1'b0}}, dx};
      end
      S_FIN: begin
        res <= dy_neg ? (y1 - div_q) : (y1 + div_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      mapped_value <= res;
      range_status <= res_stat;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bli_chk.sv =====
`default_nettype none
module bli_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [bli_pkg::KIND_W-1:0]      kind,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bli_pkg::VALUE_BITS-1:0]  mapped_value,
  input logic [bli_pkg::STAT_W-1:0]      range_status
);
  import bli_pkg::*;

  // a query beat holds off the input while the table walk runs
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind == KIND_HUM || kind == KIND_SPC)) |=> in_stall)
    else $error("query beat did not stall the input");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_WRITE) |=> !in_stall)
    else $error("write beat held the input");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (range_status == STAT_IN || range_status == STAT_LOW ||
                   range_status == STAT_HIGH))
    else $error("bad range status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(mapped_value) && $stable(range_status)))
    else $error("stalled result changed");

endmodule

bind bidirectional_linear_interp_table_unit bli_chk u_bli_chk (.*);
`default_nettype wire
